### rtl/tmw_pkg.sv
package tmw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    // Field widths
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int POS_W   = 11;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register map (register index taken from paddr[2])
    localparam logic REG_TEXT_ATTR = 1'b0;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NL      = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam int                TAB_STEP   = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_BACK  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_FILL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic copy_step;
        logic fill_step;
        logic fill_init;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic need_scroll;
        logic need_clear;
        logic copy_last;
        logic fill_last;
    } status_t;

endpackage

### rtl/tmw_ctrl.sv
module tmw_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  tmw_pkg::status_t status,
    output tmw_pkg::cmd_t    cmd
);
    import tmw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_INIT: begin
                // clearing pass after reset
                cmd.fill_step = 1'b1;
                cmd.fill_init = 1'b1;
                if (status.fill_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (status.need_scroll) begin
                    state_next = ST_COPY;
                end else if (status.need_clear) begin
                    state_next = ST_FILL;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_COPY: begin
                cmd.copy_step = 1'b1;
                if (status.copy_last) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (status.fill_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register frees up
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    s_ready      = 1'b1;
                    if (s_valid) begin
                        cmd.load_item = 1'b1;
                        state_next    = ST_EXEC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

### rtl/tmw_datapath.sv
module tmw_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tmw_pkg::cmd_t                cmd,
    output tmw_pkg::status_t             status,
    input  logic [tmw_pkg::ATTR_W-1:0]   attr,
    input  logic [tmw_pkg::OP_W-1:0]     s_operation,
    input  logic [tmw_pkg::CHAR_W-1:0]   s_char_code,
    input  logic [tmw_pkg::IDX_W-1:0]    s_cell_index,
    output logic [tmw_pkg::POS_W-1:0]    m_cursor_position,
    output logic [tmw_pkg::CELL_W-1:0]   m_read_data,
    output logic                         m_scrolled
);
    import tmw_pkg::*;

    logic [CELL_W-1:0] mem [0:CELLS-1];
    logic [CELL_W-1:0] rd_data_reg;

    op_t               op_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_next;
    logic              scr_reg;
    logic [ADDR_W-1:0] sweep_reg;

    logic [POS_W-1:0]  cpos_out_reg;
    logic [CELL_W-1:0] rdata_out_reg;
    logic              scr_out_reg;

    logic [COL_W:0]    col_w;
    logic [ROW_W:0]    row_w;
    logic              put_wr;
    logic              need_scroll;
    logic              idx_ok;
    logic              copy_last;
    logic              fill_last;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] cur_addr;

    assign idx_ok    = 32'(idx_reg) < CELLS;
    assign copy_last = sweep_reg == ADDR_W'(CELLS - COLUMNS);
    assign fill_last = sweep_reg == ADDR_W'(CELLS - 1);
    assign cur_addr  = ADDR_W'(row_reg * COLUMNS + col_reg);

    // cursor update for the item in hand
    always_comb begin
        col_w       = {1'b0, col_reg};
        row_w       = {1'b0, row_reg};
        put_wr      = 1'b0;
        need_scroll = 1'b0;
        case (op_reg)
            OP_PUT: begin
                if (ch_reg == CH_NL) begin
                    col_w = '0;
                    row_w = row_w + 1'b1;
                end else if (ch_reg == CH_CR) begin
                    col_w = '0;
                end else if (ch_reg == CH_TAB) begin
                    col_w = (col_w + (COL_W+1)'(TAB_STEP)) & ~((COL_W+1)'(TAB_STEP - 1));
                end else if (ch_reg >= CH_PRINT) begin
                    put_wr = 1'b1;
                    col_w  = col_w + 1'b1;
                end
                if (32'(col_w) >= COLUMNS) begin
                    col_w = '0;
                    row_w = row_w + 1'b1;
                end
                if (32'(row_w) >= ROWS) begin
                    need_scroll = 1'b1;
                    row_w       = (ROW_W+1)'(ROWS - 1);
                end
            end
            OP_CLEAR: begin
                col_w = '0;
                row_w = '0;
            end
            OP_BACK: begin
                if (col_reg != '0) begin
                    col_w = col_w - 1'b1;
                end else if (row_reg != '0) begin
                    row_w = row_w - 1'b1;
                    col_w = (COL_W+1)'(COLUMNS - 1);
                end
            end
            default: begin
            end
        endcase
        row_next = row_w[ROW_W-1:0];
        col_next = col_w[COL_W-1:0];
    end

    assign status.need_scroll = need_scroll;
    assign status.need_clear  = op_reg == OP_CLEAR;
    assign status.copy_last   = copy_last;
    assign status.fill_last   = fill_last;

    // store port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = {attr, ch_reg};
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(idx_reg);
        if (cmd.exec) begin
            wr_en = put_wr;
            rd_en = (op_reg == OP_READ) && idx_ok;
        end else if (cmd.copy_step) begin
            // read one row down, write back the word read in the previous copy step
            wr_en   = sweep_reg != '0;
            wr_addr = sweep_reg - 1'b1;
            wr_data = rd_data_reg;
            rd_en   = !copy_last;
            rd_addr = ADDR_W'(sweep_reg + COLUMNS);
        end else if (cmd.fill_step) begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg;
            wr_data = {(cmd.fill_init ? ATTR_RESET : attr), BLANK_CHAR};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            scr_reg   <= 1'b0;
            sweep_reg <= '0;
        end else begin
            if (cmd.exec) begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                scr_reg   <= need_scroll;
                sweep_reg <= '0;
            end else if (cmd.copy_step) begin
                if (!copy_last) begin
                    sweep_reg <= sweep_reg + 1'b1;
                end
            end else if (cmd.fill_step) begin
                sweep_reg <= fill_last ? '0 : sweep_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg  <= op_t'(s_operation);
            ch_reg  <= s_char_code;
            idx_reg <= s_cell_index;
        end
        if (cmd.out_load) begin
            cpos_out_reg  <= POS_W'(row_reg * COLUMNS + col_reg);
            rdata_out_reg <= (op_reg == OP_READ && idx_ok) ? rd_data_reg : '0;
            scr_out_reg   <= scr_reg;
        end
    end

    assign m_cursor_position = cpos_out_reg;
    assign m_read_data       = rdata_out_reg;
    assign m_scrolled        = scr_out_reg;

endmodule

### rtl/text_mode_terminal_writer.sv
// Put (no scroll), cursor back and read: the word is registered on accept, run in the exec
// state and its result loaded into the output register in the out state. Clear: the store
// is blanked, one store word written per cycle. Scroll: row copy one word per cycle through
// the store's read and write ports, then blank fill. No new word is taken before the last
// result is loaded. Reset: synchronous, active low; a clearing pass over all CELLS (2000)
// cells follows, during which no word is accepted; register writes are taken throughout.
module text_mode_terminal_writer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tmw_pkg::OP_W-1:0]            s_operation,
    input  logic [tmw_pkg::CHAR_W-1:0]          s_char_code,
    input  logic [tmw_pkg::IDX_W-1:0]           s_cell_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tmw_pkg::POS_W-1:0]           m_cursor_position,
    output logic [tmw_pkg::CELL_W-1:0]          m_read_data,
    output logic                                m_scrolled,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmw_pkg::PADDR_W-1:0]         paddr,
    input  logic [tmw_pkg::PDATA_W-1:0]         pwdata,
    output logic [tmw_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import tmw_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic [ATTR_W-1:0] attr_reg;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel == REG_TEXT_ATTR) begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    assign prdata = (reg_sel == REG_TEXT_ATTR) ? PDATA_W'(attr_reg) : '0;

    tmw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tmw_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .attr              (attr_reg),
        .s_operation       (s_operation),
        .s_char_code       (s_char_code),
        .s_cell_index      (s_cell_index),
        .m_cursor_position (m_cursor_position),
        .m_read_data       (m_read_data),
        .m_scrolled        (m_scrolled)
    );

`ifndef ASSERT_OFF
    // reset starts the clearing pass: nothing accepted, nothing shown
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !s_ready))
        else $error("block not quiet after reset");

    // one word in work at a time: no back-to-back accepts
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a word while the previous one is in work");

    // only reads return data, and reads never scroll
    a_scroll_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_scrolled) |-> (m_read_data == '0))
        else $error("scrolled result carries read data");
`endif

endmodule
